>>> design/rau_pkg.sv
package rau_pkg;

   typedef enum logic [2:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_MUL = 3'd2,
      ACT_DIV = 3'd3,
      ACT_CMP = 3'd4
   } action_type;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   // gcd engine phases
   typedef enum logic [2:0] {
      GCD_IDLE,
      GCD_STRIP,
      GCD_RUN,
      GCD_DIV,
      GCD_DONE
   } gcd_state_type;

   // back-end sequencer
   typedef enum logic [3:0] {
      BE_IDLE,
      BE_OPA,
      BE_OPA_WAIT,
      BE_OPB,
      BE_OPB_WAIT,
      BE_MUL1,
      BE_MUL2,
      BE_MUL3,
      BE_MUL4,
      BE_COMBINE,
      BE_RES,
      BE_RES_WAIT,
      BE_OUT
   } be_state_type;

endpackage

>>> design/rational_arithmetic_unit.sv
// exact add, subtract, multiply, divide and compare on signed fractions, one word
// at a time. each operand is gcd-reduced, cross products are formed on a shared
// multiplier, and except on compare the result is gcd-reduced again; every
// reduction runs on one binary gcd unit followed by a division of both parts by
// the gcd. a part whose numerator magnitude is below two skips its reduction.
// zero denominators, bad codes and divide by zero skip straight to the output.
// a two-entry queue lets the front accept while the back is busy, and the
// finished word waits in its own register so the back can take the next word
// while the result is held
module rational_arithmetic_unit #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_lhs_numerator,
   input  logic [31:0] req_lhs_denominator,
   input  logic [31:0] req_rhs_numerator,
   input  logic [31:0] req_rhs_denominator,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_numerator,
   output logic [30:0] rsp_result_denominator,
   output logic [1:0]  rsp_compare_sign,
   output logic [1:0]  rsp_status
);

   // queue head towards the back end
   logic q_valid, q_ready, q_skip, q_an, q_bn;
   logic [2:0] q_action;
   logic [1:0] q_status;
   logic [VALUE_WIDTH:0] q_anum, q_aden, q_bnum, q_bden;

   rau_front #(.VW(VALUE_WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_lhs_numerator(req_lhs_numerator), .req_lhs_denominator(req_lhs_denominator),
      .req_rhs_numerator(req_rhs_numerator), .req_rhs_denominator(req_rhs_denominator),
      .q_valid(q_valid), .q_ready(q_ready), .q_action(q_action), .q_skip(q_skip),
      .q_status(q_status), .q_an(q_an), .q_anum(q_anum), .q_aden(q_aden),
      .q_bn(q_bn), .q_bnum(q_bnum), .q_bden(q_bden)
   );

   rau_back #(.VW(VALUE_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_action(q_action), .q_skip(q_skip),
      .q_status(q_status), .q_an(q_an), .q_anum(q_anum), .q_aden(q_aden),
      .q_bn(q_bn), .q_bnum(q_bnum), .q_bden(q_bden),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_numerator(rsp_result_numerator),
      .rsp_result_denominator(rsp_result_denominator),
      .rsp_compare_sign(rsp_compare_sign), .rsp_status(rsp_status)
   );

endmodule

>>> design/rau_gcd.sv
// reduces num/den by their gcd: binary gcd, then restoring division of both parts
module rau_gcd #(
   parameter int W = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] num_out,
   output logic [W-1:0] den_out
);

   localparam int CW = $clog2(W + 1);

   rau_pkg::gcd_state_type state_ff, state_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in;
   logic [W-1:0] n_ff, n_in, d_ff, d_in;
   logic [CW-1:0] k_ff, k_in;
   logic [W-1:0] g_ff, g_in;
   // division of both numbers by g, one quotient bit per cycle each
   logic [W-1:0] qn_ff, qn_in, qd_ff, qd_in;
   logic [W:0] rn_ff, rn_in, rd_ff, rd_in;
   logic [CW-1:0] i_ff, i_in;
   logic [W:0] trn, trd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::GCD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in; y_ff <= y_in; n_ff <= n_in; d_ff <= d_in;
      k_ff <= k_in; g_ff <= g_in; qn_ff <= qn_in; qd_ff <= qd_in;
      rn_ff <= rn_in; rd_ff <= rd_in; i_ff <= i_in;
   end

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff; n_in = n_ff; d_in = d_ff;
      k_in = k_ff; g_in = g_ff; qn_in = qn_ff; qd_in = qd_ff;
      rn_in = rn_ff; rd_in = rd_ff; i_in = i_ff;
      trn = {rn_ff[W-1:0], n_ff[W-1]};
      trd = {rd_ff[W-1:0], d_ff[W-1]};
      unique case (state_ff)
         rau_pkg::GCD_IDLE: begin
            if (start) begin
               n_in = num; d_in = den; x_in = num; y_in = den;
               k_in = '0;
               if (num < W'(2) || den == '0) begin
                  qn_in = num; qd_in = den;
                  state_in = rau_pkg::GCD_DONE;
               end else begin
                  state_in = rau_pkg::GCD_STRIP;
               end
            end
         end
         rau_pkg::GCD_STRIP: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1; y_in = y_ff >> 1; k_in = k_ff + 1'b1;
            end else begin
               state_in = rau_pkg::GCD_RUN;
            end
         end
         rau_pkg::GCD_RUN: begin
            if (x_ff == '0) begin
               g_in = y_ff << k_ff;
               rn_in = '0; rd_in = '0; i_in = '0;
               state_in = rau_pkg::GCD_DIV;
            end else if (y_ff == '0) begin
               g_in = x_ff << k_ff;
               rn_in = '0; rd_in = '0; i_in = '0;
               state_in = rau_pkg::GCD_DIV;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         rau_pkg::GCD_DIV: begin
            n_in = n_ff << 1; d_in = d_ff << 1;
            if (trn >= {1'b0, g_ff}) begin
               rn_in = trn - {1'b0, g_ff}; qn_in = {qn_ff[W-2:0], 1'b1};
            end else begin
               rn_in = trn; qn_in = {qn_ff[W-2:0], 1'b0};
            end
            if (trd >= {1'b0, g_ff}) begin
               rd_in = trd - {1'b0, g_ff}; qd_in = {qd_ff[W-2:0], 1'b1};
            end else begin
               rd_in = trd; qd_in = {qd_ff[W-2:0], 1'b0};
            end
            i_in = i_ff + 1'b1;
            if (i_ff == CW'(W - 1)) state_in = rau_pkg::GCD_DONE;
         end
         rau_pkg::GCD_DONE: begin
            state_in = rau_pkg::GCD_IDLE;
         end
         default: state_in = rau_pkg::GCD_IDLE;
      endcase
   end

   assign done    = (state_ff == rau_pkg::GCD_DONE);
   assign num_out = qn_ff;
   assign den_out = qd_ff;

endmodule

>>> design/rau_front.sv
// accepts words, checks zero denominators and action code, forms magnitudes
module rau_front #(
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [2:0]    req_action,
   input  logic [31:0]   req_lhs_numerator,
   input  logic [31:0]   req_lhs_denominator,
   input  logic [31:0]   req_rhs_numerator,
   input  logic [31:0]   req_rhs_denominator,
   output logic          q_valid,
   input  logic          q_ready,
   output logic [2:0]    q_action,
   output logic          q_skip,
   output logic [1:0]    q_status,
   output logic          q_an,
   output logic [VW:0]   q_anum,
   output logic [VW:0]   q_aden,
   output logic          q_bn,
   output logic [VW:0]   q_bnum,
   output logic [VW:0]   q_bden
);

   localparam int QW = 3 + 1 + 2 + 2 + 4 * (VW + 1);
   localparam int DEPTH = 2;

   logic [VW-1:0] ln, ld, rn, rd;
   logic [VW:0] lnm, ldm, rnm, rdm;
   logic skip;
   logic [1:0] st;
   logic [QW-1:0] entry, head;
   logic [QW-1:0] fifo_ff [DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic wr_ff, wr_in, rd_ptr_ff, rd_ptr_in;
   logic push, pop;

   function automatic logic [VW:0] magn(input logic [VW-1:0] v);
      logic [VW:0] e;
      e = {v[VW-1], v};
      return v[VW-1] ? (~e + 1'b1) : e;
   endfunction

   always_comb begin
      ln = req_lhs_numerator[VW-1:0];
      ld = req_lhs_denominator[VW-1:0];
      rn = req_rhs_numerator[VW-1:0];
      rd = req_rhs_denominator[VW-1:0];
      lnm = magn(ln); ldm = magn(ld); rnm = magn(rn); rdm = magn(rd);
      skip = 1'b0;
      st = rau_pkg::STATUS_OK;
      if (req_action > 3'(rau_pkg::ACT_CMP)) begin
         skip = 1'b1;
      end else if (ld == '0 || rd == '0) begin
         skip = 1'b1; st = rau_pkg::STATUS_DIV_ZERO;
      end else if (req_action == 3'(rau_pkg::ACT_DIV) && rn == '0) begin
         skip = 1'b1; st = rau_pkg::STATUS_DIV_ZERO;
      end
      entry = {req_action, skip, st,
               2'b00,
               lnm, ldm, rnm, rdm};
      entry[QW-7] = (ln[VW-1] ^ ld[VW-1]) && ln != '0;
      entry[QW-8] = (rn[VW-1] ^ rd[VW-1]) && rn != '0;
   end

   assign req_ready = (cnt_ff != 2'(DEPTH));
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != '0);
   assign pop = q_valid && q_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wr_in = wr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; wr_ff <= 1'b0; rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; wr_ff <= wr_in; rd_ptr_ff <= rd_ptr_in;
      end
      if (push) fifo_ff[wr_ff] <= entry;
   end

   assign head = fifo_ff[rd_ptr_ff];
   assign q_action = head[QW-1:QW-3];
   assign q_skip   = head[QW-4];
   assign q_status = head[QW-5:QW-6];
   assign q_an     = head[QW-7];
   assign q_bn     = head[QW-8];
   assign q_anum   = head[4*(VW+1)-1:3*(VW+1)];
   assign q_aden   = head[3*(VW+1)-1:2*(VW+1)];
   assign q_bnum   = head[2*(VW+1)-1:VW+1];
   assign q_bden   = head[VW:0];

endmodule

>>> design/rau_back.sv
// reduces operands, forms cross products one per cycle, reduces result or compares
module rau_back #(
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_ready,
   input  logic [2:0]    q_action,
   input  logic          q_skip,
   input  logic [1:0]    q_status,
   input  logic          q_an,
   input  logic [VW:0]   q_anum,
   input  logic [VW:0]   q_aden,
   input  logic          q_bn,
   input  logic [VW:0]   q_bnum,
   input  logic [VW:0]   q_bden,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_result_numerator,
   output logic [30:0]   rsp_result_denominator,
   output logic [1:0]    rsp_compare_sign,
   output logic [1:0]    rsp_status
);

   localparam int PW = 2 * (VW + 1);
   localparam int GW = PW + 1;

   rau_pkg::be_state_type state_ff, state_in;
   logic [2:0] act_ff, act_in;
   logic an_ff, an_in, bn_ff, bn_in;
   logic [VW:0] an_num_ff, an_num_in, an_den_ff, an_den_in;
   logic [VW:0] bn_num_ff, bn_num_in, bn_den_ff, bn_den_in;
   logic [PW-1:0] p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic [VW:0] ma, mb;
   logic [PW-1:0] prod;
   logic [GW-1:0] snum_ff, snum_in, sden_ff, sden_in;
   logic sneg_ff, sneg_in;
   // finished word, held until the output register is free
   logic [31:0] rnum_ff, rnum_in;
   logic [30:0] rden_ff, rden_in;
   logic [1:0] rcmp_ff, rcmp_in, rst_ff, rst_in;
   logic ovalid_ff, ovalid_in;
   logic [31:0] onum_ff, onum_in;
   logic [30:0] oden_ff, oden_in;
   logic [1:0] ocmp_ff, ocmp_in, ost_ff, ost_in;

   logic g_start;
   logic [GW-1:0] g_num, g_den, g_nout, g_dout;
   logic g_done;
   logic bneg_eff;
   logic [GW-1:0] lim, e1, e2;
   logic [31:0] negnum;

   rau_gcd #(.W(GW)) u_gcd (
      .clock(clock), .reset(reset), .start(g_start),
      .num(g_num), .den(g_den), .done(g_done),
      .num_out(g_nout), .den_out(g_dout)
   );

   assign prod = PW'(ma) * PW'(mb);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::BE_IDLE; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ovalid_ff <= ovalid_in;
      end
      act_ff <= act_in; an_ff <= an_in; bn_ff <= bn_in;
      an_num_ff <= an_num_in; an_den_ff <= an_den_in;
      bn_num_ff <= bn_num_in; bn_den_ff <= bn_den_in;
      p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in;
      snum_ff <= snum_in; sden_ff <= sden_in; sneg_ff <= sneg_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rcmp_ff <= rcmp_in; rst_ff <= rst_in;
      onum_ff <= onum_in; oden_ff <= oden_in; ocmp_ff <= ocmp_in; ost_ff <= ost_in;
   end

   always_comb begin
      state_in = state_ff;
      act_in = act_ff; an_in = an_ff; bn_in = bn_ff;
      an_num_in = an_num_ff; an_den_in = an_den_ff;
      bn_num_in = bn_num_ff; bn_den_in = bn_den_ff;
      p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff;
      snum_in = snum_ff; sden_in = sden_ff; sneg_in = sneg_ff;
      rnum_in = rnum_ff; rden_in = rden_ff; rcmp_in = rcmp_ff; rst_in = rst_ff;
      ovalid_in = ovalid_ff;
      onum_in = onum_ff; oden_in = oden_ff; ocmp_in = ocmp_ff; ost_in = ost_ff;
      q_ready = 1'b0;
      g_start = 1'b0;
      g_num = '0; g_den = '0;
      ma = '0; mb = '0;
      bneg_eff = 1'b0;
      e1 = '0; e2 = '0;
      lim = GW'(1) << (VW - 1);
      negnum = '0;
      if (ovalid_ff && rsp_ready) ovalid_in = 1'b0;
      unique case (state_ff)
         rau_pkg::BE_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               act_in = q_action;
               an_in = q_an; bn_in = q_bn;
               an_num_in = q_anum; an_den_in = q_aden;
               bn_num_in = q_bnum; bn_den_in = q_bden;
               if (q_skip) begin
                  rnum_in = '0; rden_in = '0; rcmp_in = '0; rst_in = q_status;
                  state_in = rau_pkg::BE_OUT;
               end else begin
                  state_in = rau_pkg::BE_OPA;
               end
            end
         end
         rau_pkg::BE_OPA: begin
            g_start = 1'b1;
            g_num = GW'(an_num_ff); g_den = GW'(an_den_ff);
            state_in = rau_pkg::BE_OPA_WAIT;
         end
         rau_pkg::BE_OPA_WAIT: begin
            if (g_done) begin
               an_num_in = g_nout[VW:0]; an_den_in = g_dout[VW:0];
               state_in = rau_pkg::BE_OPB;
            end
         end
         rau_pkg::BE_OPB: begin
            g_start = 1'b1;
            g_num = GW'(bn_num_ff); g_den = GW'(bn_den_ff);
            state_in = rau_pkg::BE_OPB_WAIT;
         end
         rau_pkg::BE_OPB_WAIT: begin
            if (g_done) begin
               bn_num_in = g_nout[VW:0]; bn_den_in = g_dout[VW:0];
               state_in = rau_pkg::BE_MUL1;
            end
         end
         rau_pkg::BE_MUL1: begin
            // first term: a.num * (b.den or b.num)
            ma = an_num_ff;
            mb = (act_ff == 3'(rau_pkg::ACT_MUL)) ? bn_num_ff : bn_den_ff;
            p1_in = prod;
            state_in = rau_pkg::BE_MUL2;
         end
         rau_pkg::BE_MUL2: begin
            // second term: b.num * a.den, or divide denominator a.den * b.num
            ma = bn_num_ff; mb = an_den_ff;
            p2_in = prod;
            state_in = rau_pkg::BE_MUL3;
         end
         rau_pkg::BE_MUL3: begin
            ma = an_den_ff; mb = bn_den_ff;
            p3_in = prod;
            state_in = rau_pkg::BE_COMBINE;
         end
         rau_pkg::BE_COMBINE: begin
            unique case (act_ff) inside
               rau_pkg::ACT_ADD, rau_pkg::ACT_SUB, rau_pkg::ACT_CMP: begin
                  if (act_ff == 3'(rau_pkg::ACT_ADD))
                     bneg_eff = bn_ff;
                  else
                     bneg_eff = (bn_num_ff != '0) && !bn_ff;
                  if (an_ff == bneg_eff) begin
                     sneg_in = an_ff; snum_in = GW'(p1_ff) + GW'(p2_ff);
                  end else if (p1_ff >= p2_ff) begin
                     sneg_in = an_ff; snum_in = GW'(p1_ff - p2_ff);
                  end else begin
                     sneg_in = bneg_eff; snum_in = GW'(p2_ff - p1_ff);
                  end
                  sden_in = GW'(p3_ff);
               end
               rau_pkg::ACT_MUL: begin
                  sneg_in = an_ff ^ bn_ff; snum_in = GW'(p1_ff); sden_in = GW'(p3_ff);
               end
               default: begin
                  sneg_in = an_ff ^ bn_ff; snum_in = GW'(p1_ff); sden_in = GW'(p2_ff);
               end
            endcase
            state_in = rau_pkg::BE_RES;
            if (act_ff == 3'(rau_pkg::ACT_CMP)) state_in = rau_pkg::BE_MUL4;
         end
         rau_pkg::BE_MUL4: begin
            // compare only: sign of cross difference
            rnum_in = '0; rden_in = '0; rst_in = rau_pkg::STATUS_OK;
            if (snum_ff == '0) rcmp_in = 2'b00;
            else rcmp_in = sneg_ff ? 2'b11 : 2'b01;
            state_in = rau_pkg::BE_OUT;
         end
         rau_pkg::BE_RES: begin
            g_start = 1'b1;
            g_num = snum_ff; g_den = sden_ff;
            if (snum_ff == '0) sneg_in = 1'b0;
            state_in = rau_pkg::BE_RES_WAIT;
         end
         rau_pkg::BE_RES_WAIT: begin
            if (g_done) begin
               e1 = g_nout; e2 = g_dout;
               rcmp_in = '0;
               negnum = 32'(~e1 + 1'b1);
               if (e2 > lim - 1'b1 || e1 > (sneg_ff ? lim : lim - 1'b1)) begin
                  rnum_in = '0; rden_in = '0; rst_in = rau_pkg::STATUS_OVERFLOW;
               end else begin
                  rnum_in = sneg_ff ? negnum : 32'(e1);
                  rden_in = 31'(e2);
                  rst_in = rau_pkg::STATUS_OK;
               end
               state_in = rau_pkg::BE_OUT;
            end
         end
         rau_pkg::BE_OUT: begin
            // load the output register once its previous word has gone
            if (!ovalid_ff || rsp_ready) begin
               ovalid_in = 1'b1;
               onum_in = rnum_ff; oden_in = rden_ff; ocmp_in = rcmp_ff; ost_in = rst_ff;
               state_in = rau_pkg::BE_IDLE;
            end
         end
         default: state_in = rau_pkg::BE_IDLE;
      endcase
   end

   assign rsp_valid = ovalid_ff;
   assign rsp_result_numerator = onum_ff;
   assign rsp_result_denominator = oden_ff;
   assign rsp_compare_sign = ocmp_ff;
   assign rsp_status = ost_ff;

endmodule
